/* rtl/frm_pkg.sv */
package frm_pkg;

  // Window length of the moving average, in frame marks (1 .. 256).
  localparam int WINDOW_DEPTH = 30;

  localparam int STAMP_W  = 64;
  localparam int PERIOD_W = 32;
  localparam int RATE_W   = 16;
  localparam int REG_W    = 32;
  localparam int CFG_IDX_W = 2;

  localparam int SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  // Sum of WINDOW_DEPTH periods of PERIOD_W bits each.
  localparam int SUM_W = PERIOD_W + $clog2(WINDOW_DEPTH);
  // Numerator 2*N*freq + sum and denominator 2*sum.
  localparam int NUM_W = SUM_W + 2;
  localparam int DEN_W = SUM_W + 1;
  localparam int CNT_W = $clog2(NUM_W + 1);

  localparam logic [CFG_IDX_W-1:0] REG_TARGET_PERIOD   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMER_FREQUENCY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PERIOD      = 2'd2;

  localparam logic [REG_W-1:0] RST_TARGET_PERIOD   = 32'd166667;
  localparam logic [REG_W-1:0] RST_TIMER_FREQUENCY = 32'd10000000;
  localparam logic [REG_W-1:0] RST_MAX_PERIOD      = 32'd1000000;
  localparam logic [SUM_W-1:0] RST_WINDOW_SUM =
    SUM_W'(WINDOW_DEPTH * 166667);

  localparam logic [RATE_W-1:0] RATE_MAX = 16'hFFFF;

  // Status of the divider as seen by the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } frm_div_status_t;

endpackage

/* rtl/frm_divider.sv */
module frm_divider import frm_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] numer,
  input  logic [DEN_W-1:0] denom,
  output frm_div_status_t  status,
  output logic [NUM_W-1:0] quotient
);

  logic [CNT_W-1:0] cnt_r;
  logic             done_r;
  logic [NUM_W-1:0] num_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W-1:0] rem_r;

  logic [DEN_W:0]   trial;
  logic             qbit;
  logic [DEN_W-1:0] rem_nxt;

  // One restoring step: bring down the next numerator bit and try the subtract.
  always_comb begin
    trial   = {rem_r, num_r[NUM_W-1]};
    qbit    = (trial >= {1'b0, den_r});
    rem_nxt = qbit ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= CNT_W'(NUM_W);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  // Quotient bits shift in where numerator bits shift out.
  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= numer;
      den_r <= denom;
      rem_r <= '0;
    end else if (cnt_r != '0) begin
      num_r <= {num_r[NUM_W-2:0], qbit};
      rem_r <= rem_nxt;
    end
  end

  assign status.busy = (cnt_r != '0);
  assign status.done = done_r;
  assign quotient    = num_r;

endmodule

/* rtl/frame_rate_meter_top.sv */
// Each accepted frame mark passes through period extraction, the window update, the
// operand setup and the restoring divider, which resolves one quotient bit per cycle;
// the input takes no new mark until the result of the last one has been registered.
// Reset is synchronous and active low; it loads the register defaults, empties the
// period window (every entry reads as the target period) and drops out_tvalid.
module frame_rate_meter_top import frm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  // Input stream: one beat per frame mark.
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [63:0]          in_tdata,   // [63:0] timestamp
  // Result stream: one beat per frame mark.
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [47:0]          out_tdata,  // [15:0] rate_average, [47:16] period_used
  output logic                 out_tuser,  // [0] period_replaced
  // Configuration write port.
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_wdata
);

  // The sequencer walks each mark through period extraction, the window update,
  // the operand setup and the long division of the rate, then hands on the result.
  typedef enum logic [2:0] {
    S_IDLE,
    S_DIFF,
    S_SUM,
    S_PREP,
    S_DIV,
    S_DONE
  } state_t;

  state_t state_r;

  // Configuration registers.
  logic [REG_W-1:0] tgt_r;
  logic [REG_W-1:0] freq_r;
  logic [REG_W-1:0] max_r;

  // Window of recent periods. An entry whose valid bit is clear reads as the
  // target period, so a reset or a target write refills the window at once.
  logic [PERIOD_W-1:0]     ring_r [WINDOW_DEPTH];
  logic [WINDOW_DEPTH-1:0] ring_vld_r;
  logic [SLOT_W-1:0]       slot_r;
  logic [SUM_W-1:0]        sum_r;

  logic [STAMP_W-1:0] prev_r;
  logic               seen_r;
  logic [STAMP_W-1:0] stamp_r;

  // Per-mark working values.
  logic [PERIOD_W-1:0] period_r;
  logic                repl_r;
  logic [PERIOD_W-1:0] old_r;
  logic [SUM_W-1:0]    nf_r;
  logic [NUM_W-1:0]    numer_r;
  logic [DEN_W-1:0]    denom_r;
  logic                zero_r;
  logic                div_start_r;
  logic [RATE_W-1:0]   rate_r;

  logic                out_valid_r;
  logic [RATE_W-1:0]   out_rate_r;
  logic [PERIOD_W-1:0] out_period_r;
  logic                out_repl_r;

  logic [STAMP_W-1:0] diff_nxt;
  logic               over_nxt;
  logic [SUM_W-1:0]   sum_nxt;
  logic [SUM_W-1:0]   fill_sum_nxt;

  frm_div_status_t  div_status;
  logic [NUM_W-1:0] div_quot;

  frm_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start_r),
    .numer    (numer_r),
    .denom    (denom_r),
    .status   (div_status),
    .quotient (div_quot)
  );

  // The period wraps modulo 2^64; anything beyond 32 bits is over any limit.
  always_comb begin
    diff_nxt     = stamp_r - prev_r;
    over_nxt     = (diff_nxt[STAMP_W-1:PERIOD_W] != '0) ||
                   (diff_nxt[PERIOD_W-1:0] > max_r);
    sum_nxt      = sum_r - SUM_W'(old_r) + SUM_W'(period_r);
    fill_sum_nxt = SUM_W'(WINDOW_DEPTH) * SUM_W'(cfg_wdata);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tgt_r       <= RST_TARGET_PERIOD;
      freq_r      <= RST_TIMER_FREQUENCY;
      max_r       <= RST_MAX_PERIOD;
      ring_vld_r  <= '0;
      slot_r      <= '0;
      sum_r       <= RST_WINDOW_SUM;
      prev_r      <= '0;
      seen_r      <= 1'b0;
      div_start_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      div_start_r <= 1'b0;

      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_TARGET_PERIOD: begin
            tgt_r      <= cfg_wdata;
            ring_vld_r <= '0;
            sum_r      <= fill_sum_nxt;
          end
          REG_TIMER_FREQUENCY: freq_r <= cfg_wdata;
          REG_MAX_PERIOD:      max_r  <= cfg_wdata;
          default: ;
        endcase
      end

      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            state_r <= S_DIFF;
          end
        end
        S_DIFF: begin
          // The first mark has no previous stamp; it and an over-long period
          // fall back to the target period.
          if (!seen_r || over_nxt) begin
            period_r <= tgt_r;
            repl_r   <= 1'b1;
          end else begin
            period_r <= diff_nxt[PERIOD_W-1:0];
            repl_r   <= 1'b0;
          end
          old_r   <= ring_vld_r[slot_r] ? ring_r[slot_r] : tgt_r;
          nf_r    <= SUM_W'(WINDOW_DEPTH) * SUM_W'(freq_r);
          prev_r  <= stamp_r;
          seen_r  <= 1'b1;
          state_r <= S_SUM;
        end
        S_SUM: begin
          sum_r              <= sum_nxt;
          ring_vld_r[slot_r] <= 1'b1;
          slot_r  <= (slot_r == SLOT_W'(WINDOW_DEPTH - 1)) ? '0 : slot_r + 1'b1;
          state_r <= S_PREP;
        end
        S_PREP: begin
          // Rounded rate = (2*N*freq + sum) / (2*sum).
          numer_r     <= NUM_W'({nf_r, 1'b0}) + NUM_W'(sum_r);
          denom_r     <= {sum_r, 1'b0};
          zero_r      <= (sum_r == '0);
          div_start_r <= 1'b1;
          state_r     <= S_DIV;
        end
        S_DIV: begin
          if (div_status.done) begin
            // Saturate on a zero period sum or a quotient past 16 bits.
            if (zero_r || (div_quot[NUM_W-1:RATE_W] != '0)) begin
              rate_r <= RATE_MAX;
            end else begin
              rate_r <= div_quot[RATE_W-1:0];
            end
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          // Wait here only while an earlier result is still held.
          if (!out_valid_r || out_tready) begin
            out_valid_r  <= 1'b1;
            out_rate_r   <= rate_r;
            out_period_r <= period_r;
            out_repl_r   <= repl_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Window entries and the captured stamp carry no reset.
  always_ff @(posedge clk) begin
    if (state_r == S_SUM) begin
      ring_r[slot_r] <= period_r;
    end
    if (in_tvalid && in_tready) begin
      stamp_r <= in_tdata;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_period_r, out_rate_r};
  assign out_tuser  = out_repl_r;

endmodule

/* rtl/frm_checker.sv */
module frm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata,
  input logic        out_tuser
);

  // A held result beat keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  // One mark at a time: the input closes right after a beat is taken.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while a mark is in progress");

  // A new result appears only as the block finishes a mark.
  a_result_at_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !$past(in_tready))
    else $error("result appeared without a mark in progress");

  // Reset drops the result channel and opens the input.
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("reset did not clear the channels");

endmodule

bind frame_rate_meter_top frm_checker u_frm_checker (.*);
